// ===== src/mbss_pkg.sv =====
package mbss_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int BYTE_W      = 8;
    localparam int PAT_WORD_W  = 64;
    localparam int WILD_W      = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int OFFSET_OUT_W = 32;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN    = 2'd3;

    typedef struct packed {
        logic                    found;
        logic [OFFSET_OUT_W-1:0] offset;
    } t_result;

endpackage

// ===== src/mbss_front.sv =====
module mbss_front #(
    parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbss_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    input  logic [mbss_pkg::BYTE_W-1:0]       i_data,
    input  logic                              i_last,
    output logic                              o_ready,
    input  logic                              i_q_full,
    output logic                              o_push,
    output mbss_pkg::t_result                 o_result
);
    import mbss_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [PAT_WORD_W-1:0]  r_pat_lo;
    logic [PAT_WORD_W-1:0]  r_pat_hi;
    logic [WILD_W-1:0]      r_wild;
    logic [LEN_W-1:0]       r_len;
    logic [BYTE_W-1:0]      r_window [MAX_PATTERN];
    logic [BYTE_W-1:0]      n_window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic                   r_reported;
    logic                   n_reported;

    logic [2*PAT_WORD_W-1:0] pat_all;
    logic [LEN_W-1:0]        eff_len;
    logic [LEN_W-1:0]        len_m1;
    logic                    win_match;
    logic                    len_ok;
    logic                    hit_now;
    logic                    acc;
    logic [OFFSET_BITS-1:0]  diff;
    logic [OFFSET_OUT_W-1:0] off_out;

    assign pat_all = {r_pat_hi, r_pat_lo};
    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PAT_LO: r_pat_lo <= i_cfg_data;
                REG_PAT_HI: r_pat_hi <= i_cfg_data;
                REG_WILD:   r_wild   <= i_cfg_data[WILD_W-1:0];
                REG_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        priority if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end
    assign len_m1 = eff_len - LEN_W'(1);

    // newest byte at slot 0
    always_comb begin
        n_window[0] = i_data;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // pattern byte i lines up with the byte that arrived len-1-i steps ago
    always_comb begin
        logic [LEN_W-1:0] age;
        win_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            age = len_m1 - LEN_W'(i);
            if (LEN_W'(i) <= len_m1 && !r_wild[i] &&
                n_window[age[AW-1:0]] != pat_all[BYTE_W*i +: BYTE_W]) begin
                win_match = 1'b0;
            end
        end
    end

    assign len_ok  = r_pos >= OFFSET_BITS'(len_m1);
    assign hit_now = len_ok && win_match;
    assign diff    = r_pos - OFFSET_BITS'(len_m1);

    generate
        if (OFFSET_BITS >= OFFSET_OUT_W) begin : g_trunc
            assign off_out = diff[OFFSET_OUT_W-1:0];
        end else begin : g_ext
            assign off_out = OFFSET_OUT_W'(diff);
        end
    endgenerate

    assign o_push          = acc && !r_reported && (hit_now || i_last);
    assign o_result.found  = hit_now;
    assign o_result.offset = hit_now ? off_out : '0;

    always_comb begin
        n_pos      = r_pos;
        n_reported = r_reported;
        if (acc) begin
            if (i_last) begin
                n_pos      = '0;
                n_reported = 1'b0;
            end else begin
                if (r_pos != '1) begin
                    n_pos = r_pos + OFFSET_BITS'(1);
                end
                if (hit_now) begin
                    n_reported = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_reported <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_reported <= n_reported;
        end
    end

    // window needs no reset: only bytes of the current region are ever compared
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_window <= n_window;
        end
    end

`ifndef ASSERT_OFF
    a_latch_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && hit_now && !i_last) |=> r_reported)
        else $error("match latch not set after a hit");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> (r_pos == '0 && !r_reported))
        else $error("region state not cleared after last byte");
`endif

endmodule

// ===== src/mbss_queue.sv =====
module mbss_queue #(
    parameter int DEPTH = mbss_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbss_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output mbss_pkg::t_result o_result
);
    import mbss_pkg::*;

    localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_result        r_mem [DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           pop;
    logic           wr_en;

    assign o_full   = r_cnt == (QAW+1)'(DEPTH);
    assign o_valid  = r_cnt != '0;
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;
    assign wr_en    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == QAW'(DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QAW'(DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
            unique case ({wr_en, pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_result;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("result pushed into full queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !wr_en) |=> (r_cnt == $past(r_cnt) - (QAW+1)'(1)))
        else $error("queue count wrong after pop");
`endif

endmodule

// ===== src/masked_byte_signature_scan.sv =====
// Channel   Dir  tdata                    tuser          tlast
// s_axis    in   [7:0] data_byte          -              last_byte
// m_axis    out  [31:0] match_offset      [0] found      -
// cfg       in   i_cfg_idx / i_cfg_data   -              -
//
// One byte per cycle while the result queue is not full; the whole window
// compare and the position update run in the cycle the byte is taken, and a
// result, when one is due, enters a two-entry queue ahead of m_axis.
// Synchronous active-low reset clears position, match latch and queue.
// s_axis stalls only while the result queue is full.
module masked_byte_signature_scan #(
    parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbss_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [mbss_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // [7:0] data_byte
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [mbss_pkg::OFFSET_OUT_W-1:0] o_m_axis_tdata,  // [31:0] match_offset
    output logic [0:0]                        o_m_axis_tuser   // [0] found
);
    import mbss_pkg::*;

    logic    q_full;
    logic    push;
    t_result front_res;
    t_result back_res;

    mbss_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_result   (front_res)
    );

    mbss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_res),
        .o_full   (q_full),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (back_res)
    );

    assign o_m_axis_tdata    = back_res.offset;
    assign o_m_axis_tuser[0] = back_res.found;

endmodule
